// ===== rtl/cesc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cesc_pkg;

	// Character codes
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_OPEN      = 8'h28;
	localparam logic [7:0] CH_CLOSE     = 8'h29;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_LOWER_N   = 8'h6E;
	localparam logic [7:0] CH_LOWER_T   = 8'h74;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CH_LOWER_F   = 8'h66;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_UPPER_F   = 8'h46;

	// Most words one input byte can produce
	localparam int CMD_BYTES = 5;
	localparam int CNT_W     = $clog2(CMD_BYTES + 1);

	// Escape parser state
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_BS   = 3'd1,
		PH_OPEN = 3'd2,
		PH_HEX1 = 3'd3,
		PH_HEX2 = 3'd4
	} phase_t;

	// Burst of output words decided for one input byte; last flags the string's end
	typedef struct packed {
		logic [CNT_W-1:0]              cnt;
		logic                          last;
		logic [CMD_BYTES-1:0][7:0]     bytes;
	} cmd_t;

	function automatic logic hex_ok(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) ||
		       (c >= CH_LOWER_A && c <= CH_LOWER_F) ||
		       (c >= CH_UPPER_A && c <= CH_UPPER_F);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = c - CH_ZERO;
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
			v = c - CH_LOWER_A + 8'd10;
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
			v = c - CH_UPPER_A + 8'd10;
		end
		return v[3:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cesc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cesc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire logic [7:0]    in_byte,
	input  wire logic          in_last,
	output logic               cmd_push,
	output cesc_pkg::cmd_t     cmd,
	input  wire logic          cmd_full
);
	import cesc_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] hex1_q, hex2_q;
	logic       accept;
	logic       is_hex;
	logic       is_bs;
	logic       is_map;
	logic [7:0] map_byte;
	phase_t     idle_next;
	logic       feed_idle;
	logic [2:0] pre_n;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	// Byte classification
	assign is_hex = hex_ok(in_byte);
	assign is_bs  = (in_byte == CH_BACKSLASH);
	always_comb begin
		is_map   = 1'b1;
		map_byte = CH_BACKSLASH;
		unique case (in_byte)
			CH_LOWER_R:   map_byte = CH_CR;
			CH_LOWER_N:   map_byte = CH_LF;
			CH_LOWER_T:   map_byte = CH_TAB;
			CH_BACKSLASH: map_byte = CH_BACKSLASH;
			default:      is_map   = 1'b0;
		endcase
	end

	// A byte seen from idle opens an escape only if a backslash not at end
	assign idle_next = (is_bs && !in_last) ? PH_BS : PH_IDLE;

	// Next state
	always_comb begin
		phase_d = PH_IDLE;
		unique case (phase_q)
			PH_BS: begin
				if (is_map) begin
					phase_d = PH_IDLE;
				end else if (in_byte == CH_OPEN) begin
					phase_d = in_last ? PH_IDLE : PH_OPEN;
				end else begin
					phase_d = idle_next;
				end
			end
			PH_OPEN: phase_d = (is_hex && !in_last) ? PH_HEX1 : idle_next;
			PH_HEX1: phase_d = (is_hex && !in_last) ? PH_HEX2 : idle_next;
			PH_HEX2: phase_d = (in_byte == CH_CLOSE) ? PH_IDLE : idle_next;
			default: phase_d = idle_next;
		endcase
	end

	// Output burst: literal prefix of a broken escape, then the byte replayed from idle
	always_comb begin
		cmd.cnt   = '0;
		cmd.last  = in_last;
		cmd.bytes = '0;
		pre_n     = 3'd0;
		feed_idle = 1'b0;
		unique case (phase_q)
			PH_BS: begin
				if (is_map) begin
					cmd.bytes[0] = map_byte;
					cmd.cnt      = CNT_W'(1);
				end else if (in_byte == CH_OPEN) begin
					if (in_last) begin
						cmd.bytes[0] = CH_BACKSLASH;
						cmd.bytes[1] = CH_OPEN;
						cmd.cnt      = CNT_W'(2);
					end
				end else begin
					cmd.bytes[0] = CH_BACKSLASH;
					pre_n        = 3'd1;
					feed_idle    = 1'b1;
				end
			end
			PH_OPEN: begin
				if (!(is_hex && !in_last)) begin
					cmd.bytes[0] = CH_BACKSLASH;
					cmd.bytes[1] = CH_OPEN;
					pre_n        = 3'd2;
					feed_idle    = 1'b1;
				end
			end
			PH_HEX1: begin
				if (!(is_hex && !in_last)) begin
					cmd.bytes[0] = CH_BACKSLASH;
					cmd.bytes[1] = CH_OPEN;
					cmd.bytes[2] = hex1_q;
					pre_n        = 3'd3;
					feed_idle    = 1'b1;
				end
			end
			PH_HEX2: begin
				if (in_byte == CH_CLOSE) begin
					cmd.bytes[0] = {hex_val(hex1_q), hex_val(hex2_q)};
					cmd.cnt      = CNT_W'(1);
				end else begin
					cmd.bytes[0] = CH_BACKSLASH;
					cmd.bytes[1] = CH_OPEN;
					cmd.bytes[2] = hex1_q;
					cmd.bytes[3] = hex2_q;
					pre_n        = 3'd4;
					feed_idle    = 1'b1;
				end
			end
			default: feed_idle = 1'b1;
		endcase
		if (feed_idle) begin
			if (!is_bs || in_last) begin
				cmd.bytes[pre_n] = in_byte;
				cmd.cnt          = CNT_W'(pre_n + 3'd1);
			end else begin
				cmd.cnt = CNT_W'(pre_n);
			end
		end
	end

	// Empty bursts are dropped here
	assign cmd_push = accept && (cmd.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hex1_q  <= 8'd0;
			hex2_q  <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			if (phase_q == PH_OPEN) begin
				hex1_q <= in_byte;
			end
			if (phase_q == PH_HEX1) begin
				hex2_q <= in_byte;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cesc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cesc_queue (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  cesc_pkg::cmd_t wdata,
	output logic           full,
	input  wire logic      pop,
	output cesc_pkg::cmd_t rdata,
	output logic           valid
);
	import cesc_pkg::*;

	// Two-slot queue: head is presented, tail catches a burst while head is held
	cmd_t head_q, tail_q;
	logic head_v_q, tail_v_q;
	logic do_push, do_pop;

	assign full    = tail_v_q;
	assign valid   = head_v_q;
	assign rdata   = head_q;
	assign do_push = push && !tail_v_q;
	assign do_pop  = pop && head_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			tail_v_q <= 1'b0;
		end else begin
			if (do_pop && tail_v_q) begin
				tail_v_q <= 1'b0;
			end else if (do_pop) begin
				head_v_q <= do_push;
			end else if (do_push) begin
				if (head_v_q) begin
					tail_v_q <= 1'b1;
				end else begin
					head_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop && tail_v_q) begin
			head_q <= tail_q;
		end else if (do_push && (!head_v_q || do_pop)) begin
			head_q <= wdata;
		end
		if (do_push && head_v_q && !do_pop) begin
			tail_q <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cesc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cesc_back (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	input  cesc_pkg::cmd_t  cmd,
	output logic            cmd_pop,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_byte,
	output logic            out_last
);
	import cesc_pkg::*;

	logic [CNT_W-1:0]          cur_cnt_q;
	logic                      cur_last_q;
	logic [CMD_BYTES-1:0][7:0] cur_bytes_q;
	logic                      out_v_q;
	logic [7:0]                out_byte_q;
	logic                      out_last_q;
	logic                      out_free;
	logic                      advance;
	logic                      load;

	assign empty    = !out_v_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

	// One word per cycle while popped; refill as a burst's last word leaves
	assign out_free = !out_v_q || pop;
	assign advance  = out_free && (cur_cnt_q != '0);
	assign load     = cmd_valid &&
	                  ((cur_cnt_q == '0) || ((cur_cnt_q == CNT_W'(1)) && advance));
	assign cmd_pop  = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_cnt_q <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (load) begin
				cur_cnt_q <= cmd.cnt;
			end else if (advance) begin
				cur_cnt_q <= cur_cnt_q - CNT_W'(1);
			end
			if (advance) begin
				out_v_q <= 1'b1;
			end else if (out_free) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Burst payload shifts down one word per emitted word
	always_ff @(posedge clk) begin
		if (load) begin
			cur_last_q  <= cmd.last;
			cur_bytes_q <= cmd.bytes;
		end else if (advance) begin
			cur_bytes_q <= {8'd0, cur_bytes_q[CMD_BYTES-1:1]};
		end
		if (advance) begin
			out_byte_q <= cur_bytes_q[0];
			out_last_q <= cur_last_q && (cur_cnt_q == CNT_W'(1));
		end
	end

endmodule

`default_nettype wire

// ===== rtl/c_escape_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Backslash-escape decoder for a byte stream marked with an end-of-string flag.
// Source bytes enter through push/full; decoded words leave through empty/pop,
// out_last set on the final word of each string. A parser front end turns each
// source byte into a burst of zero to five words (a broken escape replays its
// backslash and buffered bytes literally), a two-slot queue holds the bursts,
// and an emitter back end sends one word per cycle while the output is popped.
// Plain text runs at one byte per cycle while the output is popped; a byte
// yielding several words holds the emitter until its burst drains; the input
// backs up through the queue while bursts drain or the output is not popped.
// A word passes the queue head and the emitter's burst and output registers. A
// byte that opens or continues an escape produces nothing until it resolves.
module c_escape_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_byte,
	output logic            out_last
);
	import cesc_pkg::*;

	cmd_t f_cmd, q_cmd;
	logic f_push, q_full, q_valid, b_pop;

	cesc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.cmd_push (f_push),
		.cmd      (f_cmd),
		.cmd_full (q_full)
	);

	cesc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_cmd),
		.full   (q_full),
		.pop    (b_pop),
		.rdata  (q_cmd),
		.valid  (q_valid)
	);

	cesc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (b_pop),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

`default_nettype wire
